// File: design/nva_pkg.sv
package nva_pkg;

  // slot storage and time arithmetic
  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 32;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = $clog2(SLOTS + 1);

  // fixed port widths
  localparam int DELTA_W = 32;
  localparam int KEY_W   = 7;
  localparam int GRP_W   = 2;
  localparam int MT_W    = 5;
  localparam int VOICE_W = 4;
  localparam int OUT_T_W = 32;

  localparam int SUM_W = ((TIME_BITS > DELTA_W) ? TIME_BITS : DELTA_W) + 1;
  localparam int CMP_W = (SLOT_W > MT_W) ? SLOT_W : MT_W;

  localparam logic [TIME_BITS-1:0] TIME_MAX       = '1;
  localparam logic [MT_W-1:0]      MAX_TRACKS_RST = MT_W'(16);

  // grouping codes
  localparam logic [GRP_W-1:0] GRP_START = 2'd0;
  localparam logic [GRP_W-1:0] GRP_END   = 2'd1;

  typedef enum logic [1:0] {
    ST_EMIT     = 2'd0,
    ST_NOT_NOTE = 2'd1,
    ST_DROP     = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  // elapsed time plus delta, clamped to the largest storable value
  function automatic logic [TIME_BITS-1:0] sat_add(
    input logic [TIME_BITS-1:0] e,
    input logic [DELTA_W-1:0]   d
  );
    logic [SUM_W-1:0] s;
    s = SUM_W'(e) + SUM_W'(d);
    if (s > SUM_W'(TIME_MAX)) begin
      return TIME_MAX;
    end
    return TIME_BITS'(s);
  endfunction

endpackage

// File: design/nva_ctrl.sv
module nva_ctrl
  import nva_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/nva_datapath.sv
module nva_datapath
  import nva_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  input  logic [DELTA_W-1:0]  delta_time,
  input  logic                is_note,
  input  logic [KEY_W-1:0]    note_key,
  input  logic [GRP_W-1:0]    grouping,
  input  logic                cfg_wr,
  input  logic [MT_W-1:0]     cfg_data,
  output logic                done,
  output logic [1:0]          status,
  output logic [VOICE_W-1:0]  voice,
  output logic [OUT_T_W-1:0]  time_on_voice
);

  // captured request
  logic [DELTA_W-1:0] req_delta;
  logic               req_note;
  logic [KEY_W-1:0]   req_key;
  logic [GRP_W-1:0]   req_grp;

  // slot state
  logic [MT_W-1:0]      max_tracks;
  logic [CNT_W-1:0]     slots_opened;
  logic [SLOTS-1:0]     slot_busy;
  logic [KEY_W-1:0]     slot_key     [SLOTS];
  logic [TIME_BITS-1:0] slot_elapsed [SLOTS];

  // per-lane results
  logic [SLOTS-1:0]     opened;
  logic [SLOTS-1:0]     hit_vec;
  logic [SLOTS-1:0]     idle_vec;
  logic [TIME_BITS-1:0] elapsed_sum  [SLOTS];

  logic              hit_found;
  logic              idle_found;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] idle_idx;
  logic [SLOT_W-1:0] sel;
  logic              sel_new;
  logic              sel_ok;
  logic [TIME_BITS-1:0] sel_time;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_delta <= delta_time;
      req_note  <= is_note;
      req_key   <= note_key;
      req_grp   <= grouping;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      opened[i]      = CNT_W'(i) < slots_opened;
      hit_vec[i]     = opened[i] && slot_busy[i] && (slot_key[i] == req_key);
      idle_vec[i]    = opened[i] && !slot_busy[i];
      elapsed_sum[i] = sat_add(slot_elapsed[i], req_delta);
    end
  end

  // lowest matching busy slot, lowest idle slot
  always_comb begin
    hit_found  = 1'b0;
    idle_found = 1'b0;
    hit_idx    = '0;
    idle_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!hit_found && hit_vec[i]) begin
        hit_found = 1'b1;
        hit_idx   = SLOT_W'(i);
      end
      if (!idle_found && idle_vec[i]) begin
        idle_found = 1'b1;
        idle_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    sel     = '0;
    sel_new = 1'b0;
    sel_ok  = 1'b1;
    if (hit_found) begin
      sel = hit_idx;
    end else if (idle_found) begin
      sel = idle_idx;
    end else if (slots_opened < CNT_W'(SLOTS)) begin
      sel     = SLOT_W'(slots_opened);
      sel_new = 1'b1;
    end else begin
      sel_ok = 1'b0;
    end
    sel_time = sel_new ? '0 : elapsed_sum[sel];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tracks <= MAX_TRACKS_RST;
    end else if (cfg_wr) begin
      max_tracks <= cfg_data;
    end
  end

  // slot updates
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_opened <= '0;
      slot_busy    <= '0;
    end else if (cmd.exec && req_note && sel_ok) begin
      if (sel_new) begin
        slots_opened <= slots_opened + CNT_W'(1);
      end
      if (req_grp == GRP_START) begin
        slot_busy[sel] <= 1'b1;
      end else if (req_grp == GRP_END) begin
        slot_busy[sel] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (opened[i]) begin
          slot_elapsed[i] <= elapsed_sum[i];
        end
      end
      if (req_note && sel_ok) begin
        slot_elapsed[sel] <= '0;
        if (req_grp == GRP_START) begin
          slot_key[sel] <= req_key;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      voice         <= '0;
      time_on_voice <= '0;
      if (!req_note) begin
        status <= ST_NOT_NOTE;
      end else if (!sel_ok) begin
        status <= ST_FULL;
      end else if (CMP_W'(sel) < CMP_W'(max_tracks)) begin
        status        <= ST_EMIT;
        voice         <= VOICE_W'(sel);
        time_on_voice <= OUT_T_W'(sel_time);
      end else begin
        status <= ST_DROP;
      end
    end
  end

  a_done_follows_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.exec))
    else $error("result strobe without an exec step");

  a_opened_bound: assert property (@(posedge clk) disable iff (rst)
    slots_opened <= CNT_W'(SLOTS))
    else $error("opened slot count beyond slot storage");

  a_busy_in_opened: assert property (@(posedge clk) disable iff (rst)
    (slot_busy & ~opened) == '0)
    else $error("busy flag set on a slot never opened");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_EMIT) |-> (voice == '0 && time_on_voice == '0))
    else $error("voice or time nonzero on a non-emitted result");

  a_open_step: assert property (@(posedge clk) disable iff (rst)
    (slots_opened != $past(slots_opened)) |->
      (slots_opened == $past(slots_opened) + CNT_W'(1) && $past(cmd.exec)))
    else $error("slot count moved by other than one exec step");

endmodule

// File: design/note_voice_allocator.sv
// sequencing: a request is captured while idle, then the exec step registers the result and raises done
// a new request is taken only while busy is low; the single exec step updates every slot lane
//   (saturating time add, key compare, first-free pick) in parallel
// reset: all slots closed and idle, track limit back to 16, no result pending
// results are strobed for one cycle and cannot be stalled by the receiver
module note_voice_allocator
  import nva_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                start,
  output logic                busy,
  input  logic [DELTA_W-1:0]  delta_time,
  input  logic                is_note,
  input  logic [KEY_W-1:0]    note_key,
  input  logic [GRP_W-1:0]    grouping,
  // track limit register write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MT_W-1:0]     cfg_data,
  // result channel
  output logic                done,
  output logic [1:0]          status,
  output logic [VOICE_W-1:0]  voice,
  output logic [OUT_T_W-1:0]  time_on_voice
);

  ctrl_cmd_t cmd;

  // the limit register is always writable; the user must write only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  // sequencing: capture the request, then one exec step
  nva_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // slot lanes, voice pick and result register
  nva_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .delta_time    (delta_time),
    .is_note       (is_note),
    .note_key      (note_key),
    .grouping      (grouping),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .voice         (voice),
    .time_on_voice (time_on_voice)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import nva_pkg::*;

  // grouping values the package leaves unnamed
  localparam logic [GRP_W-1:0] GRP_NEITHER = 2'd2;
  localparam logic [GRP_W-1:0] GRP_ODD     = 2'd3;

  localparam logic [DELTA_W-1:0] DELTA_MAX = '1;

  // settle margin after the last result, covering any stray work
  localparam int SETTLE_CYCLES = 8;
  // hard stop sized for ~2000 requests, taken many times over
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct {
    status_t              status;
    logic [VOICE_W-1:0]   voice;
    logic [OUT_T_W-1:0]   elapsed;
  } voice_result_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [DELTA_W-1:0]  delta_time;
  logic                is_note;
  logic [KEY_W-1:0]    note_key;
  logic [GRP_W-1:0]    grouping;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [MT_W-1:0]     cfg_data;
  logic                done;
  logic [1:0]          status;
  logic [VOICE_W-1:0]  voice;
  logic [OUT_T_W-1:0]  time_on_voice;

  note_voice_allocator DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .delta_time    (delta_time),
    .is_note       (is_note),
    .note_key      (note_key),
    .grouping      (grouping),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .voice         (voice),
    .time_on_voice (time_on_voice)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // chance in a hundred that the sender holds start low before a request
  int idle_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  // expected results, oldest first
  voice_result_t pending_voices[$];

  // allocator shadow state
  int                   opened_count;
  int                   track_limit;
  logic                 held[SLOTS];
  logic [KEY_W-1:0]     held_key[SLOTS];
  logic [TIME_BITS-1:0] slot_ticks[SLOTS];

  // hard stop in case the block hangs or loses a result
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    mismatches++;
  endtask

  // elapsed plus delta, pinned at the top of the time range
  function automatic logic [TIME_BITS-1:0] add_ticks(input logic [TIME_BITS-1:0] e,
                                                    input logic [DELTA_W-1:0] d);
    logic [TIME_BITS:0] s;
    s = {1'b0, e} + (TIME_BITS + 1)'(d);
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  task automatic clear_allocator();
    opened_count = 0;
    track_limit  = 16;
    for (int i = 0; i < SLOTS; i++) begin
      held[i]       = 1'b0;
      held_key[i]   = '0;
      slot_ticks[i] = '0;
    end
  endtask

  // what the block should answer for one event, updating the shadow slots
  task automatic assign_voice(input logic [DELTA_W-1:0] delta, input logic note,
                              input logic [KEY_W-1:0] key, input logic [GRP_W-1:0] grp,
                              output voice_result_t res);
    int hit;
    int idle;
    int slot;
    hit = -1;
    idle = -1;
    // every opened slot ages, whatever the event is
    for (int i = 0; i < opened_count; i++) begin
      slot_ticks[i] = add_ticks(slot_ticks[i], delta);
    end
    res.status  = ST_NOT_NOTE;
    res.voice   = '0;
    res.elapsed = '0;
    if (!note) return;
    // a held key wins; otherwise remember the lowest idle slot
    for (int i = 0; i < opened_count; i++) begin
      if (held[i] && held_key[i] == key) begin
        hit = i;
        break;
      end
      if (idle < 0 && !held[i]) idle = i;
    end
    if (hit >= 0) begin
      slot = hit;
    end else if (idle >= 0) begin
      slot = idle;
    end else if (opened_count < SLOTS) begin
      // open a fresh slot with no elapsed time
      slot = opened_count;
      opened_count++;
      held[slot]       = 1'b0;
      slot_ticks[slot] = '0;
    end else begin
      // every slot busy with another key: nothing changes
      res.status = ST_FULL;
      return;
    end
    if (slot < track_limit) begin
      res.status  = ST_EMIT;
      res.voice   = VOICE_W'(slot);
      res.elapsed = OUT_T_W'(slot_ticks[slot]);
    end else begin
      // beyond the track limit the slot still updates but stays silent
      res.status = ST_DROP;
    end
    slot_ticks[slot] = '0;
    if (grp == GRP_START) begin
      held[slot]     = 1'b1;
      held_key[slot] = key;
    end else if (grp == GRP_END) begin
      held[slot] = 1'b0;
    end
  endtask

  // one request: drive at the falling edge, hold until taken while not busy
  task automatic send_event(input logic [DELTA_W-1:0] delta, input logic note,
                            input logic [KEY_W-1:0] key, input logic [GRP_W-1:0] grp);
    voice_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    delta_time <= delta;
    is_note    <= note;
    note_key   <= key;
    grouping   <= grp;
    @(posedge clk);
    while (busy) @(posedge clk);
    assign_voice(delta, note, key, grp, res);
    pending_voices.push_back(res);
  endtask

  // drop start and let every outstanding result come back
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_voices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_track_limit(input int value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= MT_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    track_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // results are strobed for one cycle; compare each with the oldest expectation
  always @(posedge clk) begin : check_results
    voice_result_t want;
    if (!rst && done) begin
      if (pending_voices.size() == 0) begin
        report_mismatch("result with no request waiting", 32'(status), 32'hx);
      end else begin
        want = pending_voices.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (voice !== want.voice)
          report_mismatch("voice", 32'(voice), 32'(want.voice));
        if (time_on_voice !== want.elapsed)
          report_mismatch("time_on_voice", time_on_voice, want.elapsed);
      end
    end
  end

  // timing-only events, first slots, saturation, idle reuse, odd grouping
  task automatic test_first_notes();
    send_event(DELTA_MAX, 1'b0, 7'h55, GRP_ODD);        // nothing opened yet
    send_event('0, 1'b1, 7'h00, GRP_START);             // opens slot 0
    send_event(DELTA_MAX, 1'b0, 7'h00, GRP_NEITHER);    // slot 0 pinned at max
    send_event(DELTA_MAX, 1'b1, 7'h7F, GRP_START);      // opens slot 1
    send_event(32'd5, 1'b1, 7'h00, GRP_END);            // releases saturated slot 0
    send_event(32'd1, 1'b1, 7'h05, GRP_NEITHER);        // idle slot 0, stays idle
    send_event(32'd2, 1'b1, 7'h05, GRP_ODD);            // odd grouping acts as neither
    send_event(32'hAAAA_5555, 1'b1, 7'h7F, GRP_START);  // retrigger on held key
  endtask

  // fill all slots, hit the full case, then free and reuse one
  task automatic test_slot_exhaustion();
    for (int k = 0; k < SLOTS - 1; k++) begin
      send_event(DELTA_W'(k * 3), 1'b1, KEY_W'(20 + k), GRP_START);
    end
    send_event(32'd9, 1'b1, 7'h40, GRP_START);          // no slot free
    send_event(32'd1, 1'b1, 7'h40, GRP_END);            // still no slot free
    send_event(32'd4, 1'b1, 7'd25, GRP_END);            // frees a held slot
    send_event(32'd6, 1'b1, 7'h40, GRP_START);          // lands on that freed slot
  endtask

  // track limit at the extremes and in between
  task automatic test_track_limit();
    write_track_limit(4);
    send_event(32'd3, 1'b1, 7'd30, GRP_END);            // high slot, dropped
    send_event(32'd3, 1'b1, 7'h7F, GRP_END);            // slot 1 still emits
    write_track_limit(0);
    send_event(DELTA_MAX, 1'b1, 7'd20, GRP_NEITHER);    // even slot 0 drops
    write_track_limit(16);
    send_event(32'd7, 1'b1, 7'd34, GRP_END);            // top slot emits again
  endtask

  // mostly note on/off traffic over a key pool, with noise mixed in
  task automatic send_random_event(input int key_base, input int key_span);
    int                 pick;
    logic [DELTA_W-1:0] delta;
    logic               note;
    logic [KEY_W-1:0]   key;
    logic [GRP_W-1:0]   grp;
    logic [KEY_W-1:0]   held_keys[$];
    case ($urandom_range(9))
      0, 1, 2: delta = '0;
      3, 4, 5: delta = DELTA_W'($urandom_range(1000));
      6, 7:    delta = $urandom;
      8:       delta = DELTA_MAX;
      default: delta = 32'hF000_0000 | $urandom;
    endcase
    note = 1'b1;
    key  = KEY_W'(key_base + $urandom_range(key_span - 1));
    grp  = GRP_NEITHER;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // timing-only event
      note = 1'b0;
      key  = KEY_W'($urandom_range(127));
      grp  = GRP_W'($urandom_range(3));
    end else if (pick < 20) begin
      // stray note outside the pool
      key = KEY_W'($urandom_range(127));
      grp = GRP_W'($urandom_range(3));
    end else if (pick < 60) begin
      grp = GRP_START;
    end else if (pick < 92) begin
      // note off, usually for a key that is actually sounding
      grp = GRP_END;
      for (int i = 0; i < opened_count; i++) begin
        if (held[i]) held_keys.push_back(held_key[i]);
      end
      if (held_keys.size() != 0 && $urandom_range(9) != 0)
        key = held_keys[$urandom_range(held_keys.size() - 1)];
    end
    send_event(delta, note, key, grp);
  endtask

  // four track limits, each with a fresh key pool
  task automatic test_random_traffic(input int pct, input int lim0, input int lim1,
                                     input int lim2, input int lim3);
    int limits[4];
    int key_base;
    int key_span;
    limits = '{lim0, lim1, lim2, lim3};
    idle_pct = pct;
    for (int p = 0; p < 4; p++) begin
      write_track_limit(limits[p]);
      key_base = $urandom_range(127);
      // narrow pools give many retriggers, wide ones fill every slot
      key_span = 6 << $urandom_range(3);
      repeat (160) send_random_event(key_base, key_span);
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    delta_time = '0;
    is_note    = 1'b0;
    note_key   = '0;
    grouping   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    clear_allocator();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_notes();
    test_slot_exhaustion();
    test_track_limit();
    test_random_traffic(15, 16, 0, 5, 12);
    test_random_traffic(75, 1, 15, 8, $urandom_range(16));
    test_random_traffic(0, 3, 16, 0, $urandom_range(16));

    wait_idle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
